@@ design/lpc_pkg.sv @@
// ----------------------------------------------------------------------------
// lpc_pkg: shared types, constants and AES helper functions
// Holds the payload structs, the S-box and the round helpers for the cipher.
// ----------------------------------------------------------------------------
package lpc_pkg;

   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        first_byte;
      logic        last_byte;
      logic [31:0] dev_address;
      logic        downlink;
      logic [31:0] frame_counter;
   } req_type;

   typedef struct packed {
      logic [7:0] cipher_byte;
      logic       frame_end;
   } rsp_type;

   // item classified by the front part
   typedef struct packed {
      logic [7:0]   payload_byte;
      logic         last_byte;
      logic         new_block;
      logic [3:0]   position;
      logic [127:0] a_block;
   } job_type;

   localparam logic [1:0] REG_KEY_HIGH = 2'd0;
   localparam logic [1:0] REG_KEY_LOW  = 2'd1;
   localparam logic [7:0] A_BLOCK_TAG  = 8'h01;
   localparam int         AES_ROUNDS   = 10;
   // nominal frame size; longer frames keep going with a wrapping block counter
   localparam int         MAX_FRAME_BYTES = 256;

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] t [256];
      t = '{
 8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
 8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
 8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
 8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
 8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
 8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
 8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
 8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
 8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
 8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
 8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
 8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
 8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
 8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
 8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
 8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[x];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of a 128-bit word sits at bits 127-8i .. 120-8i
   function automatic logic [7:0] byte_of(input logic [127:0] w, input int i);
      return w[127 - 8*i -: 8];
   endfunction

   // one AES round: SubBytes, ShiftRows, MixColumns unless last, AddRoundKey
   function automatic logic [127:0] aes_round(input logic [127:0] s,
                                              input logic [127:0] rk,
                                              input logic last);
      logic [7:0]   t [16];
      logic [7:0]   a0, a1, a2, a3, all;
      logic [127:0] r;
      for (int c = 0; c < 4; c++)
         for (int i = 0; i < 4; i++)
            t[i + 4*c] = sbox(byte_of(s, i + 4*((c + i) % 4)));
      if (!last) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            all = a0 ^ a1 ^ a2 ^ a3;
            t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
            t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
            t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
            t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++)
         r[127 - 8*i -: 8] = t[i];
      return r ^ rk;
   endfunction

   // next round key from the previous one
   function automatic logic [127:0] key_step(input logic [127:0] k,
                                             input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, g;
      {w0, w1, w2, w3} = k;
      g  = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
      w0 = w0 ^ g;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   function automatic logic [7:0] rcon(input logic [3:0] r);
      logic [7:0] v;
      unique case (r)
         4'd1:    v = 8'h01;
         4'd2:    v = 8'h02;
         4'd3:    v = 8'h04;
         4'd4:    v = 8'h08;
         4'd5:    v = 8'h10;
         4'd6:    v = 8'h20;
         4'd7:    v = 8'h40;
         4'd8:    v = 8'h80;
         4'd9:    v = 8'h1b;
         4'd10:   v = 8'h36;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

endpackage

@@ design/lpc_front.sv @@
// ----------------------------------------------------------------------------
// lpc_front: frame tracking and A-block builder
// Latches the frame fields, counts the byte position and block counter, and
// turns each accepted byte into a job for the cipher back end.
// ----------------------------------------------------------------------------
module lpc_front import lpc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    job_valid,
   input  logic    job_stall,
   output job_type job_data
);

   logic [3:0]  pos_ff, pos_in;
   logic [7:0]  bctr_ff, bctr_in;
   logic [31:0] addr_ff, addr_in, fcnt_ff, fcnt_in;
   logic        dir_ff, dir_in;
   logic        accept;
   logic [3:0]  pos_use;
   logic [7:0]  bctr_use;

   assign req_stall = job_stall;
   assign job_valid = req_valid;
   assign accept    = req_valid && !job_stall;

   // select latched or fresh frame fields
   always_comb begin
      addr_in  = req_data.first_byte ? req_data.dev_address   : addr_ff;
      dir_in   = req_data.first_byte ? req_data.downlink      : dir_ff;
      fcnt_in  = req_data.first_byte ? req_data.frame_counter : fcnt_ff;
      bctr_use = req_data.first_byte ? 8'd1 : bctr_ff;
      pos_use  = req_data.first_byte ? 4'd0 : pos_ff;
      bctr_in  = (pos_use == 4'd0) ? bctr_use + 8'd1 : bctr_use;
      pos_in   = req_data.last_byte ? 4'd0 : pos_use + 4'd1;
   end

   // build the job
   always_comb begin
      job_data.payload_byte = req_data.payload_byte;
      job_data.last_byte    = req_data.last_byte;
      job_data.new_block    = (pos_use == 4'd0);
      job_data.position     = pos_use;
      job_data.a_block      = {A_BLOCK_TAG, 32'd0, 7'd0, dir_in,
                               addr_in[7:0], addr_in[15:8], addr_in[23:16], addr_in[31:24],
                               fcnt_in[7:0], fcnt_in[15:8], fcnt_in[23:16], fcnt_in[31:24],
                               8'd0, bctr_use};
   end

   // advance frame state on accept
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= 4'd0;
         bctr_ff <= 8'd1;
         addr_ff <= 32'd0;
         dir_ff  <= 1'b0;
         fcnt_ff <= 32'd0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         bctr_ff <= bctr_in;
         addr_ff <= addr_in;
         dir_ff  <= dir_in;
         fcnt_ff <= fcnt_in;
      end
   end

endmodule

@@ design/lpc_queue.sv @@
// ----------------------------------------------------------------------------
// lpc_queue: two-entry job queue
// Decouples the front end from the cipher back end.
// ----------------------------------------------------------------------------
module lpc_queue import lpc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_stall,
   input  job_type in_data,
   output logic    out_valid,
   input  logic    out_stall,
   output job_type out_data
);

   job_type    mem_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_stall  = (cnt_ff == 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rptr_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   // store entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= in_data;
      end
   end

   // advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         if (push) wptr_ff <= !wptr_ff;
         if (pop)  rptr_ff <= !rptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

@@ design/lpc_back.sv @@
// ----------------------------------------------------------------------------
// lpc_back: AES-128 round pipeline and keystream XOR
// Ten registered round stages encrypt each job's A block; the keystream block
// is held and each byte is XORed with its lane at the pipeline exit.
// ----------------------------------------------------------------------------
module lpc_back import lpc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic [127:0] key,
   input  logic         job_valid,
   output logic         job_stall,
   input  job_type      job_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_data
);

   localparam int NS = AES_ROUNDS + 1;

   logic         vld_ff   [NS];
   job_type      job_ff   [NS];
   logic [127:0] st_ff    [NS];
   logic [127:0] rk_ff    [NS];
   logic         advance;
   logic [127:0] ks_ff, ks_in, ks_use;
   logic         out_valid_ff;
   rsp_type      out_ff, out_in;
   logic         out_free;

   // output register drains or is empty; pipeline moves as one
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = out_free;
   assign job_stall = !advance;

   // stage 0 adds the whitening key; stages 1..10 run one round each
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NS; s++) vld_ff[s] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= job_valid;
         for (int s = 1; s < NS; s++) vld_ff[s] <= vld_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         job_ff[0] <= job_data;
         st_ff[0]  <= job_data.a_block ^ key;
         rk_ff[0]  <= key;
         for (int s = 1; s < NS; s++) begin
            job_ff[s] <= job_ff[s-1];
            rk_ff[s]  <= key_step(rk_ff[s-1], rcon(4'(s)));
            st_ff[s]  <= aes_round(st_ff[s-1], key_step(rk_ff[s-1], rcon(4'(s))),
                                   s == AES_ROUNDS);
         end
      end
   end

   // pick keystream and XOR the byte lane
   always_comb begin
      ks_use = job_ff[NS-1].new_block ? st_ff[NS-1] : ks_ff;
      ks_in  = ks_use;
      out_in.cipher_byte = job_ff[NS-1].payload_byte ^
                           byte_of(ks_use, int'(job_ff[NS-1].position));
      out_in.frame_end   = job_ff[NS-1].last_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ks_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= vld_ff[NS-1];
         if (vld_ff[NS-1]) ks_ff <= ks_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

@@ design/lorawan_payload_ctr_cipher_top.sv @@
// ----------------------------------------------------------------------------
// lorawan_payload_ctr_cipher_top: LoRaWAN FRMPayload AES-128 counter cipher
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_type
//   rsp      out        rsp_valid/rsp_stall  rsp_type
//   csr      in         APB write/read       key_high, key_low (64 bit)
//
// One byte per cycle while rsp is not stalled; a result passes through the
// queue entry, the whitening stage, the ten AES round stages and the
// output register.
// Reset sets the block counter to 1 and clears the rest of the frame state, keys, keystream and all valid flags.
// A stall on rsp while a result is held freezes the cipher pipeline; the
// queue then fills its two entries and stalls req.
// ----------------------------------------------------------------------------
module lorawan_payload_ctr_cipher_top import lpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   logic [63:0] key_high_ff, key_low_ff;
   logic        fr_valid, fr_stall, bk_valid, bk_stall;
   job_type     fr_job, bk_job;
   logic [1:0]  reg_index;

   assign pready    = 1'b1;
   assign reg_index = paddr[3] ? REG_KEY_LOW : REG_KEY_HIGH;

   // write key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
         unique case (paddr[3])
            1'b0: key_high_ff <= pwdata;
            1'b1: key_low_ff  <= pwdata;
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (reg_index)
         REG_KEY_HIGH: prdata = key_high_ff;
         REG_KEY_LOW:  prdata = key_low_ff;
         default:      prdata = 64'd0;
      endcase
   end

   lpc_front u_front (
      .clock, .reset,
      .req_valid, .req_stall, .req_data,
      .job_valid(fr_valid), .job_stall(fr_stall), .job_data(fr_job)
   );

   lpc_queue u_queue (
      .clock, .reset,
      .in_valid(fr_valid), .in_stall(fr_stall), .in_data(fr_job),
      .out_valid(bk_valid), .out_stall(bk_stall), .out_data(bk_job)
   );

   lpc_back u_back (
      .clock, .reset,
      .key({key_high_ff, key_low_ff}),
      .job_valid(bk_valid), .job_stall(bk_stall), .job_data(bk_job),
      .rsp_valid, .rsp_stall, .rsp_data
   );

endmodule
